### hdl/bank_switch_mapper_latch_irq_defines.svh
// assertion macros used by the mapper rtl
`ifndef BANK_SWITCH_MAPPER_LATCH_IRQ_DEFINES_SVH
`define BANK_SWITCH_MAPPER_LATCH_IRQ_DEFINES_SVH

// same-cycle implication under reset
`define BSM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("bsm check failed");

// next-cycle implication under reset
`define BSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("bsm check failed");

`endif

### hdl/bsm_pkg.sv
package bsm_pkg;

  // item operation codes
  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_PPU_FETCH = 2'd1,
    OP_A12_RISE  = 2'd2
  } op_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_REV_A_IRQ_MODE    = 2'd0,
    CFG_PRG_BANK_MASK     = 2'd1,
    CFG_INITIAL_MIRRORING = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // cpu register decode
  localparam logic [15:0] CpuDecodeMask = 16'hE001;
  localparam logic [15:0] RegBankSelect = 16'h8000;
  localparam logic [15:0] RegBankData   = 16'h8001;
  localparam logic [15:0] RegMirroring  = 16'hA000;
  localparam logic [15:0] RegWramCtrl   = 16'hA001;
  localparam logic [15:0] RegIrqReload  = 16'hC000;
  localparam logic [15:0] RegIrqClear   = 16'hC001;
  localparam logic [15:0] RegIrqDisable = 16'hE000;
  localparam logic [15:0] RegIrqEnable  = 16'hE001;

  // tile latch fetch decode
  localparam logic [15:0] FetchMask  = 16'h1FF0;
  localparam logic [15:0] FetchLowFd = 16'h0FD0;
  localparam logic [15:0] FetchLowFe = 16'h0FE0;
  localparam logic [15:0] FetchHiFd  = 16'h1FD0;
  localparam logic [15:0] FetchHiFe  = 16'h1FE0;

  localparam logic [2:0] NumChrRegs   = 3'd6;
  localparam logic [1:0] MirrorFour   = 2'd2;
  localparam logic [7:0] PrgMaskReset = 8'd63;
  localparam logic [7:0] ReloadReset  = 8'hFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  value;
  } item_t;

  typedef struct packed {
    logic       rev_a_irq_mode;
    logic [7:0] prg_bank_mask;
    logic [1:0] initial_mirroring;
  } cfg_t;

  typedef struct packed {
    logic [2:0]      bank_select;
    logic            prg_swap;
    logic [5:0][7:0] chr_regs;
    logic [1:0][7:0] prg_regs;
    logic            low_latch_fe;
    logic            high_latch_fe;
    logic            irq_enable;
    logic [7:0]      irq_count;
    logic [7:0]      reload_val;
    logic            irq_clear_flag;
    logic            irq_pending;
    logic            mirror;
    logic            wram_enable;
    logic            wram_writable;
  } state_t;

  typedef struct packed {
    logic       irq_line;
    logic [5:0] chr_low_bank;
    logic       chr_low_is_rom;
    logic [5:0] chr_high_bank;
    logic       chr_high_is_rom;
    logic [7:0] prg_bank_8000;
    logic [7:0] prg_bank_a000;
    logic [7:0] prg_bank_c000;
    logic [7:0] prg_bank_e000;
    logic [1:0] mirror_mode;
    logic       wram_enable;
    logic       wram_writable;
  } result_t;

endpackage

### hdl/bsm_if.sv
// input item channel
interface bsm_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  value;
  modport source (output valid, output operation, output address, output value, input ready);
  modport sink   (input valid, input operation, input address, input value, output ready);
endinterface

// result item channel
interface bsm_result_if;
  logic       valid;
  logic       ready;
  logic       irq_line;
  logic [5:0] chr_low_bank;
  logic       chr_low_is_rom;
  logic [5:0] chr_high_bank;
  logic       chr_high_is_rom;
  logic [7:0] prg_bank_8000;
  logic [7:0] prg_bank_a000;
  logic [7:0] prg_bank_c000;
  logic [7:0] prg_bank_e000;
  logic [1:0] mirror_mode;
  logic       wram_enable;
  logic       wram_writable;
  modport source (output valid, output irq_line, output chr_low_bank, output chr_low_is_rom,
                  output chr_high_bank, output chr_high_is_rom, output prg_bank_8000,
                  output prg_bank_a000, output prg_bank_c000, output prg_bank_e000,
                  output mirror_mode, output wram_enable, output wram_writable,
                  input ready);
  modport sink   (input valid, input irq_line, input chr_low_bank, input chr_low_is_rom,
                  input chr_high_bank, input chr_high_is_rom, input prg_bank_8000,
                  input prg_bank_a000, input prg_bank_c000, input prg_bank_e000,
                  input mirror_mode, input wram_enable, input wram_writable,
                  output ready);
endinterface

// configuration write channel
interface bsm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [bsm_pkg::CfgIdxW-1:0]  index;
  logic [bsm_pkg::CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/bsm_core.sv
module bsm_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  bsm_pkg::item_t               item_i,
  input  logic                         cfg_we_i,
  input  logic [bsm_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bsm_pkg::CfgDataW-1:0] cfg_data_i,
  output bsm_pkg::cfg_t                cfg_o,
  output bsm_pkg::state_t              state_q_o,
  output bsm_pkg::state_t              state_d_o
);

  bsm_pkg::cfg_t   cfg_q, cfg_d;
  bsm_pkg::state_t state_q, state_d;

  logic [15:0] cpu_reg;
  logic [15:0] fetch_tag;
  logic [7:0]  count_next;
  logic        count_reload;

  assign cpu_reg   = item_i.address & bsm_pkg::CpuDecodeMask;
  assign fetch_tag = item_i.address & bsm_pkg::FetchMask;

  // scanline counter step
  assign count_reload = (state_q.irq_count == 8'd0) || state_q.irq_clear_flag;
  assign count_next   = count_reload ? state_q.reload_val : (state_q.irq_count - 8'd1);

  // configuration writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bsm_pkg::cfg_idx_e'(cfg_index_i))
        bsm_pkg::CFG_REV_A_IRQ_MODE:    cfg_d.rev_a_irq_mode = cfg_data_i[0];
        bsm_pkg::CFG_PRG_BANK_MASK:     cfg_d.prg_bank_mask = cfg_data_i;
        bsm_pkg::CFG_INITIAL_MIRRORING: cfg_d.initial_mirroring = cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // state update for one item and for initial mirroring writes
  always_comb begin
    state_d = state_q;
    if (cfg_we_i && (bsm_pkg::cfg_idx_e'(cfg_index_i) == bsm_pkg::CFG_INITIAL_MIRRORING)) begin
      state_d.mirror = cfg_data_i[0];
    end
    if (step_i) begin
      unique case (bsm_pkg::op_e'(item_i.operation))
        bsm_pkg::OP_CPU_WRITE: begin
          unique case (cpu_reg)
            bsm_pkg::RegBankSelect: begin
              state_d.bank_select = item_i.value[2:0];
              state_d.prg_swap    = item_i.value[6];
            end
            bsm_pkg::RegBankData: begin
              if (state_q.bank_select < bsm_pkg::NumChrRegs) begin
                state_d.chr_regs[state_q.bank_select] = item_i.value;
              end else begin
                state_d.prg_regs[state_q.bank_select[0]] = item_i.value & cfg_q.prg_bank_mask;
              end
            end
            bsm_pkg::RegMirroring: begin
              if (!cfg_q.initial_mirroring[1]) begin
                state_d.mirror = item_i.value[0];
              end
            end
            bsm_pkg::RegWramCtrl: begin
              state_d.wram_enable   = item_i.value[7];
              state_d.wram_writable = !item_i.value[6];
            end
            bsm_pkg::RegIrqReload: state_d.reload_val = item_i.value;
            bsm_pkg::RegIrqClear: begin
              if (cfg_q.rev_a_irq_mode) begin
                state_d.irq_clear_flag = 1'b1;
              end
              state_d.irq_count = 8'd0;
            end
            bsm_pkg::RegIrqDisable: begin
              state_d.irq_enable  = 1'b0;
              state_d.irq_pending = 1'b0;
            end
            bsm_pkg::RegIrqEnable: state_d.irq_enable = 1'b1;
            default: ;
          endcase
        end
        bsm_pkg::OP_PPU_FETCH: begin
          priority if (fetch_tag == bsm_pkg::FetchLowFd) begin
            state_d.low_latch_fe = 1'b0;
          end else if (fetch_tag == bsm_pkg::FetchLowFe) begin
            state_d.low_latch_fe = 1'b1;
          end else if (fetch_tag == bsm_pkg::FetchHiFd) begin
            state_d.high_latch_fe = 1'b0;
          end else if (fetch_tag == bsm_pkg::FetchHiFe) begin
            state_d.high_latch_fe = 1'b1;
          end
        end
        bsm_pkg::OP_A12_RISE: begin
          state_d.irq_count      = count_next;
          state_d.irq_clear_flag = 1'b0;
          if ((!cfg_q.rev_a_irq_mode || (state_q.irq_count != 8'd0) || state_q.irq_clear_flag)
              && (count_next == 8'd0) && state_q.irq_enable) begin
            state_d.irq_pending = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rev_a_irq_mode    <= 1'b0;
      cfg_q.prg_bank_mask     <= bsm_pkg::PrgMaskReset;
      cfg_q.initial_mirroring <= 2'd0;
      state_q.bank_select     <= 3'd0;
      state_q.prg_swap        <= 1'b0;
      state_q.chr_regs        <= '0;
      state_q.prg_regs[0]     <= 8'd0;
      state_q.prg_regs[1]     <= 8'd1;
      state_q.low_latch_fe    <= 1'b1;
      state_q.high_latch_fe   <= 1'b1;
      state_q.irq_enable      <= 1'b0;
      state_q.irq_count       <= 8'd0;
      state_q.reload_val      <= bsm_pkg::ReloadReset;
      state_q.irq_clear_flag  <= 1'b0;
      state_q.irq_pending     <= 1'b0;
      state_q.mirror          <= 1'b0;
      state_q.wram_enable     <= 1'b1;
      state_q.wram_writable   <= 1'b1;
    end else begin
      cfg_q   <= cfg_d;
      state_q <= state_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign state_q_o = state_q;
  assign state_d_o = state_d;

endmodule

### hdl/bsm_map.sv
module bsm_map (
  input  bsm_pkg::cfg_t    cfg_i,
  input  bsm_pkg::state_t  state_i,
  output bsm_pkg::result_t result_o
);

  logic [7:0] chr_lo;
  logic [7:0] chr_hi;
  logic [7:0] prg_fixed;

  // tile latches pick the 4k windows
  assign chr_lo    = state_i.low_latch_fe ? state_i.chr_regs[1] : state_i.chr_regs[0];
  assign chr_hi    = state_i.high_latch_fe ? state_i.chr_regs[4] : state_i.chr_regs[2];
  assign prg_fixed = cfg_i.prg_bank_mask - 8'd1;

  // bank map
  always_comb begin
    result_o.irq_line        = state_i.irq_pending;
    result_o.chr_low_bank    = chr_lo[7:2];
    result_o.chr_low_is_rom  = (chr_lo != 8'd0);
    result_o.chr_high_bank   = chr_hi[7:2];
    result_o.chr_high_is_rom = (chr_hi != 8'd0);
    result_o.prg_bank_8000   = state_i.prg_swap ? prg_fixed : state_i.prg_regs[0];
    result_o.prg_bank_a000   = state_i.prg_regs[1];
    result_o.prg_bank_c000   = state_i.prg_swap ? state_i.prg_regs[0] : prg_fixed;
    result_o.prg_bank_e000   = cfg_i.prg_bank_mask;
    result_o.mirror_mode     = cfg_i.initial_mirroring[1] ? bsm_pkg::MirrorFour
                                                           : {1'b0, state_i.mirror};
    result_o.wram_enable     = state_i.wram_enable;
    result_o.wram_writable   = state_i.wram_writable;
  end

endmodule

### hdl/bank_switch_mapper_latch_irq.sv
// an accepted item is held in the input register and its result in the result register
// throughput: one item per cycle, sustained whenever the result side takes items
// the input register and result register form a two-stage pipe with stall on result
// reset (rst_ni low, asynchronous) clears the pipe and loads the power-up mapper registers
`include "bank_switch_mapper_latch_irq_defines.svh"

module bank_switch_mapper_latch_irq (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsm_item_if.sink     item_i,
  bsm_result_if.source result_o,
  bsm_cfg_if.sink      cfg_i
);

  logic             in_valid_q;
  bsm_pkg::item_t   in_item_q;
  logic             out_valid_q;
  bsm_pkg::result_t out_q;

  logic             advance;
  logic             step;
  bsm_pkg::cfg_t    cfg;
  bsm_pkg::state_t  state_q;
  bsm_pkg::state_t  state_d;
  bsm_pkg::result_t map;

  // pipe control
  assign advance      = !out_valid_q || result_o.ready;
  assign step         = in_valid_q && advance;
  assign item_i.ready = !in_valid_q || advance;
  assign cfg_i.ready  = 1'b1;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (item_i.ready) begin
      in_valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_i.ready && item_i.valid) begin
      in_item_q.operation <= item_i.operation;
      in_item_q.address   <= item_i.address;
      in_item_q.value     <= item_i.value;
    end
  end

  bsm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (in_item_q),
    .cfg_we_i    (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .cfg_o       (cfg),
    .state_q_o   (state_q),
    .state_d_o   (state_d)
  );

  bsm_map u_map (
    .cfg_i    (cfg),
    .state_i  (state_d),
    .result_o (map)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= map;
    end
  end

  assign result_o.valid           = out_valid_q;
  assign result_o.irq_line        = out_q.irq_line;
  assign result_o.chr_low_bank    = out_q.chr_low_bank;
  assign result_o.chr_low_is_rom  = out_q.chr_low_is_rom;
  assign result_o.chr_high_bank   = out_q.chr_high_bank;
  assign result_o.chr_high_is_rom = out_q.chr_high_is_rom;
  assign result_o.prg_bank_8000   = out_q.prg_bank_8000;
  assign result_o.prg_bank_a000   = out_q.prg_bank_a000;
  assign result_o.prg_bank_c000   = out_q.prg_bank_c000;
  assign result_o.prg_bank_e000   = out_q.prg_bank_e000;
  assign result_o.mirror_mode     = out_q.mirror_mode;
  assign result_o.wram_enable     = out_q.wram_enable;
  assign result_o.wram_writable   = out_q.wram_writable;

  // checks
  `BSM_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_q, item_i.ready)
  `BSM_ASSERT_IMPLY(a_irq_rise_enabled, clk_i, rst_ni, $rose(state_q.irq_pending), state_q.irq_enable)
  `BSM_ASSERT_NEXT(a_irq_holds_idle, clk_i, rst_ni, state_q.irq_pending && !step, state_q.irq_pending)

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import bsm_pkg::*;

  localparam int QuietLimit = 4000;
  localparam int BurstItems = 150;
  localparam int NumPhases  = 7;

  // power-up bank map under the reset register values
  localparam result_t ResetMap = {1'b0, 6'd0, 1'b0, 6'd0, 1'b0, 8'd0, 8'd1, 8'd62, 8'd63,
                                  2'd0, 1'b1, 1'b1};
  localparam result_t NoMap = '0;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } dir_row_t;

  // shadow copy of the mapper registers
  typedef struct {
    logic [2:0] sel;
    logic       swap;
    logic [7:0] chr [6];
    logic [7:0] prg [2];
    logic       lo_fe;
    logic       hi_fe;
    logic       irq_en;
    logic [7:0] count;
    logic [7:0] reload;
    logic       clear_flag;
    logic       pending;
    logic       mirror;
    logic       wram_en;
    logic       wram_wr;
  } mapper_shadow_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  bsm_item_if   itm ();
  bsm_result_if res ();
  bsm_cfg_if    cfg ();

  bank_switch_mapper_latch_irq dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (itm),
    .result_o (res),
    .cfg_i    (cfg)
  );

  mapper_shadow_t shadow;
  logic           cfg_rev_a;
  logic [7:0]     cfg_prg_mask;
  logic [1:0]     cfg_mirroring;

  result_t expected_maps [$];
  dir_row_t dir_rows [0:27];
  result_t got;
  result_t want;

  int src_idle_pct;
  int sink_idle_pct;
  int stall_left;
  int quiet;
  int mismatches;
  int items_sent;
  int results_seen;
  int irq_results;
  int cfg_writes;
  logic       rv;
  logic [7:0] mk;
  logic [1:0] mr;

  // clock
  always #2 clk_i = ~clk_i;

  // bank map after one item, updating the shadow registers
  function automatic result_t next_bank_map(input item_t it);
    logic [7:0]  old_count;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [7:0]  fixed_c;
    logic [15:0] m;
    result_t     r;
    case (it.operation)
      OP_CPU_WRITE: begin
        case (it.address & CpuDecodeMask)
          RegBankSelect: begin
            shadow.sel  = it.value[2:0];
            shadow.swap = it.value[6];
          end
          RegBankData: begin
            if (shadow.sel < NumChrRegs) shadow.chr[shadow.sel] = it.value;
            else shadow.prg[shadow.sel[0]] = it.value & cfg_prg_mask;
          end
          // four-screen boards ignore mirroring writes
          RegMirroring: if (!cfg_mirroring[1]) shadow.mirror = it.value[0];
          RegWramCtrl: begin
            shadow.wram_en = it.value[7];
            shadow.wram_wr = !it.value[6];
          end
          RegIrqReload: shadow.reload = it.value;
          RegIrqClear: begin
            if (cfg_rev_a) shadow.clear_flag = 1'b1;
            shadow.count = 8'd0;
          end
          RegIrqDisable: begin
            shadow.irq_en  = 1'b0;
            shadow.pending = 1'b0;
          end
          RegIrqEnable: shadow.irq_en = 1'b1;
          default: ;
        endcase
      end
      OP_PPU_FETCH: begin
        m = it.address & FetchMask;
        if (m == FetchLowFd) shadow.lo_fe = 1'b0;
        else if (m == FetchLowFe) shadow.lo_fe = 1'b1;
        else if (m == FetchHiFd) shadow.hi_fe = 1'b0;
        else if (m == FetchHiFe) shadow.hi_fe = 1'b1;
      end
      OP_A12_RISE: begin
        old_count = shadow.count;
        if (shadow.count == 8'd0 || shadow.clear_flag) shadow.count = shadow.reload;
        else shadow.count = shadow.count - 8'd1;
        if ((!cfg_rev_a || old_count != 8'd0 || shadow.clear_flag) &&
            shadow.count == 8'd0 && shadow.irq_en) shadow.pending = 1'b1;
        shadow.clear_flag = 1'b0;
      end
      default: ;
    endcase
    // latch-selected chr windows, fixed prg windows at the top
    lo      = shadow.lo_fe ? shadow.chr[1] : shadow.chr[0];
    hi      = shadow.hi_fe ? shadow.chr[4] : shadow.chr[2];
    fixed_c = cfg_prg_mask - 8'd1;
    r.irq_line        = shadow.pending;
    r.chr_low_bank    = lo[7:2];
    r.chr_low_is_rom  = (lo != 8'd0);
    r.chr_high_bank   = hi[7:2];
    r.chr_high_is_rom = (hi != 8'd0);
    r.prg_bank_8000   = shadow.swap ? fixed_c : shadow.prg[0];
    r.prg_bank_a000   = shadow.prg[1];
    r.prg_bank_c000   = shadow.swap ? shadow.prg[0] : fixed_c;
    r.prg_bank_e000   = cfg_prg_mask;
    r.mirror_mode     = cfg_mirroring[1] ? MirrorFour : {1'b0, shadow.mirror};
    r.wram_enable     = shadow.wram_en;
    r.wram_writable   = shadow.wram_wr;
    return r;
  endfunction

  function automatic item_t pack_item(input logic [1:0] op, input logic [15:0] a,
                                      input logic [7:0] v);
    item_t it;
    it.operation = op;
    it.address   = a;
    it.value     = v;
    return it;
  endfunction

  // cpu write with random don't-care address bits
  function automatic item_t cpu_wr(input logic [15:0] reg_code, input logic [7:0] v);
    return pack_item(OP_CPU_WRITE, reg_code | (16'($urandom) & ~CpuDecodeMask), v);
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, exp_v, got_v);
    end
  endtask

  // offer one item, predict its map once taken; valid stays high afterwards
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      itm.valid <= 1'b0;
      @(posedge clk_i);
    end
    itm.valid     <= 1'b1;
    itm.operation <= it.operation;
    itm.address   <= it.address;
    itm.value     <= it.value;
    @(posedge clk_i);
    while (itm.ready !== 1'b1) @(posedge clk_i);
    expected_maps.push_back(next_bank_map(it));
    items_sent++;
  endtask

  // register write; valid stays high for back-to-back writes
  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk_i);
    while (cfg.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      CFG_REV_A_IRQ_MODE: cfg_rev_a = data[0];
      CFG_PRG_BANK_MASK:  cfg_prg_mask = data;
      CFG_INITIAL_MIRRORING: begin
        cfg_mirroring = data[1:0];
        shadow.mirror = data[0];
      end
      default: ;
    endcase
    cfg_writes++;
  endtask

  // random traffic, mostly well-formed register sequences
  task automatic random_burst(input int n);
    int          start;
    int          k;
    logic [15:0] a;
    start = items_sent;
    while (items_sent - start < n) begin
      k = $urandom_range(99);
      if (k < 30) begin
        send_item(cpu_wr(RegBankSelect, 8'($urandom)));
        send_item(cpu_wr(RegBankData, 8'($urandom)));
      end else if (k < 45) begin
        // tile fetch, mostly on the latch trigger addresses
        case ($urandom_range(4))
          0:       a = FetchLowFd;
          1:       a = FetchLowFe;
          2:       a = FetchHiFd;
          3:       a = FetchHiFe;
          default: a = 16'($urandom) & FetchMask;
        endcase
        send_item(pack_item(OP_PPU_FETCH, a | (16'($urandom) & ~FetchMask), 8'($urandom)));
      end else if (k < 65) begin
        repeat ($urandom_range(1, 6))
          send_item(pack_item(OP_A12_RISE, 16'($urandom), 8'($urandom)));
      end else if (k < 75) begin
        // arm the counter with a short reload
        send_item(cpu_wr(RegIrqReload, ($urandom_range(3) == 0) ? 8'($urandom)
                                                                : 8'($urandom_range(4))));
        send_item(cpu_wr(RegIrqClear, 8'($urandom)));
        send_item(cpu_wr(RegIrqEnable, 8'($urandom)));
      end else if (k < 80) begin
        send_item(cpu_wr(RegIrqDisable, 8'($urandom)));
      end else if (k < 88) begin
        send_item(cpu_wr($urandom_range(1) ? RegMirroring : RegWramCtrl, 8'($urandom)));
      end else begin
        send_item(pack_item(2'($urandom), 16'($urandom), 8'($urandom)));
      end
    end
  endtask

  // result side: ready pattern, checking and watchdog
  always @(posedge clk_i) begin
    if ((itm.valid === 1'b1 && itm.ready === 1'b1) ||
        (cfg.valid === 1'b1 && cfg.ready === 1'b1) ||
        (res.valid === 1'b1 && res.ready === 1'b1)) quiet = 0;
    else quiet++;
    if (res.valid === 1'b1 && res.ready === 1'b1) begin
      got = {res.irq_line, res.chr_low_bank, res.chr_low_is_rom, res.chr_high_bank,
             res.chr_high_is_rom, res.prg_bank_8000, res.prg_bank_a000, res.prg_bank_c000,
             res.prg_bank_e000, res.mirror_mode, res.wram_enable, res.wram_writable};
      if (expected_maps.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result item, expected none got %h", $time, got);
      end else begin
        want = expected_maps.pop_front();
        check_field("irq_line", 8'(want.irq_line), 8'(got.irq_line));
        check_field("chr_low_bank", 8'(want.chr_low_bank), 8'(got.chr_low_bank));
        check_field("chr_low_is_rom", 8'(want.chr_low_is_rom), 8'(got.chr_low_is_rom));
        check_field("chr_high_bank", 8'(want.chr_high_bank), 8'(got.chr_high_bank));
        check_field("chr_high_is_rom", 8'(want.chr_high_is_rom), 8'(got.chr_high_is_rom));
        check_field("prg_bank_8000", want.prg_bank_8000, got.prg_bank_8000);
        check_field("prg_bank_a000", want.prg_bank_a000, got.prg_bank_a000);
        check_field("prg_bank_c000", want.prg_bank_c000, got.prg_bank_c000);
        check_field("prg_bank_e000", want.prg_bank_e000, got.prg_bank_e000);
        check_field("mirror_mode", 8'(want.mirror_mode), 8'(got.mirror_mode));
        check_field("wram_enable", 8'(want.wram_enable), 8'(got.wram_enable));
        check_field("wram_writable", 8'(want.wram_writable), 8'(got.wram_writable));
      end
      results_seen++;
      if (got.irq_line) irq_results++;
      // one long hold-off so the pipe fills and the input stalls
      if (results_seen == 400) stall_left = 80;
    end
    if (stall_left != 0) begin
      stall_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
    if (quiet >= QuietLimit) begin
      $display("bank_switch_mapper_latch_irq regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    rst_ni        <= 1'b0;
    itm.valid     <= 1'b0;
    itm.operation <= OP_CPU_WRITE;
    itm.address   <= '0;
    itm.value     <= '0;
    cfg.valid     <= 1'b0;
    cfg.index     <= CFG_REV_A_IRQ_MODE;
    cfg.data      <= '0;
    src_idle_pct  = 13;
    sink_idle_pct = 64;
    stall_left    = 0;
    quiet         = 0;
    mismatches    = 0;
    items_sent    = 0;
    results_seen  = 0;
    irq_results   = 0;
    cfg_writes    = 0;

    // power-up register contents
    cfg_rev_a         = 1'b0;
    cfg_prg_mask      = PrgMaskReset;
    cfg_mirroring     = 2'd0;
    shadow.sel        = '0;
    shadow.swap       = 1'b0;
    foreach (shadow.chr[i]) shadow.chr[i] = '0;
    shadow.prg[0]     = 8'd0;
    shadow.prg[1]     = 8'd1;
    shadow.lo_fe      = 1'b1;
    shadow.hi_fe      = 1'b1;
    shadow.irq_en     = 1'b0;
    shadow.count      = '0;
    shadow.reload     = ReloadReset;
    shadow.clear_flag = 1'b0;
    shadow.pending    = 1'b0;
    shadow.mirror     = 1'b0;
    shadow.wram_en    = 1'b1;
    shadow.wram_wr    = 1'b1;

    // directed rows: unknown op and ignored write, bank loads, latches, mirroring, wram, irq
    dir_rows = '{
      {2'd3,         16'hFFFF, 8'hFF, 1'b1, ResetMap},
      {OP_CPU_WRITE, 16'h7FFF, 8'hFF, 1'b1, ResetMap},
      {OP_CPU_WRITE, 16'h8000, 8'h40, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'hFF, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h9FFE, 8'h01, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'h80, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8000, 8'h02, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'h04, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8000, 8'h03, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'h33, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8000, 8'h04, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'hFC, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8000, 8'h06, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8001, 8'hFF, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h8000, 8'hC7, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'h9FFF, 8'h00, 1'b0, NoMap},
      {OP_PPU_FETCH, 16'h0FD0, 8'h00, 1'b0, NoMap},
      {OP_PPU_FETCH, 16'h1FD8, 8'h00, 1'b0, NoMap},
      {OP_PPU_FETCH, 16'hEFEF, 8'hFF, 1'b0, NoMap},
      {OP_PPU_FETCH, 16'hFFE5, 8'hAA, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hA000, 8'h01, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hA001, 8'h40, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hC000, 8'h01, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hE001, 8'h00, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hC001, 8'h00, 1'b0, NoMap},
      {OP_A12_RISE,  16'h0000, 8'h00, 1'b0, NoMap},
      {OP_A12_RISE,  16'hFFFF, 8'hFF, 1'b0, NoMap},
      {OP_CPU_WRITE, 16'hE000, 8'h00, 1'b0, NoMap}
    };

    // reset
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].it);
      if (dir_rows[i].typed) expected_maps[expected_maps.size() - 1] = dir_rows[i].want;
    end
    itm.valid <= 1'b0;

    // register settings per phase, extremes first
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 2) begin
        src_idle_pct  = 64;
        sink_idle_pct = 13;
      end
      if (p == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      while (expected_maps.size() != 0) @(posedge clk_i);
      case (p)
        0: begin rv = 1'b1; mk = 8'd255; mr = 2'd1; end
        1: begin rv = 1'b0; mk = 8'd0;   mr = 2'd2; end
        2: begin rv = 1'b1; mk = 8'd7;   mr = 2'd3; end
        3: begin rv = 1'b0; mk = 8'd1;   mr = 2'd0; end
        default: begin
          rv = 1'($urandom);
          mk = 8'($urandom);
          mr = 2'($urandom);
        end
      endcase
      write_reg(CFG_REV_A_IRQ_MODE, {7'($urandom), rv});
      write_reg(CFG_PRG_BANK_MASK, mk);
      write_reg(CFG_INITIAL_MIRRORING, {6'($urandom), mr});
      cfg.valid <= 1'b0;
      random_burst(BurstItems);
      itm.valid <= 1'b0;
    end

    // drain and let the pipe settle
    while (expected_maps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d items and %0d register writes over %0d settings", items_sent,
             cfg_writes, NumPhases + 1);
    $display("checked %0d bank maps, %0d with the irq line raised, mismatches %0d",
             results_seen, irq_results, mismatches);
    if (mismatches == 0) begin
      $display("bank_switch_mapper_latch_irq regression: pass");
    end else begin
      $display("bank_switch_mapper_latch_irq regression: fail");
    end
    $finish;
  end

endmodule
